/* rtl/tfd_pkg.sv */
// shared types, constants and helpers for the texel format decoder
package tfd_pkg;

  // palette geometry
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  // image pixel counter width
  localparam int COUNT_BITS = 20;

  // field widths
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PIX_IDX_W  = 3;
  localparam int HELD_W     = 24;
  localparam int WORD_W     = HELD_W + 8;

  // texel formats
  typedef enum logic [3:0] {
    FMT_RGBA16 = 4'd0,
    FMT_RGBA32 = 4'd1,
    FMT_IA16   = 4'd2,
    FMT_IA8    = 4'd3,
    FMT_IA4    = 4'd4,
    FMT_IA1    = 4'd5,
    FMT_I8     = 4'd6,
    FMT_I4     = 4'd7,
    FMT_CI8    = 4'd8
  } tex_fmt_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  // input item operations
  typedef enum logic {
    OP_TEXEL   = 1'b0,
    OP_PALETTE = 1'b1
  } item_op_e;

  // one decoded pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pix_t;

  // 5-bit to 8-bit widening, v*255/31 truncated
  localparam logic [7:0] WIDEN5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // index of the final pixel a byte produces
  function automatic logic [PIX_IDX_W-1:0] pix_last(tex_fmt_e f);
    logic [PIX_IDX_W-1:0] r;
    unique case (f)
      FMT_IA4, FMT_I4: r = PIX_IDX_W'(1);
      FMT_IA1:         r = PIX_IDX_W'(7);
      default:         r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tfd_pixel.sv */
// combinational decode of one pixel from a completed texel word
module tfd_pixel (
  input  tfd_pkg::tex_fmt_e              fmt_i,
  input  logic [tfd_pkg::WORD_W-1:0]     word_i,
  input  logic [15:0]                    pal_word_i,
  input  logic [tfd_pkg::PIX_IDX_W-1:0]  idx_i,
  output tfd_pkg::pix_t                  pix_o
);
  import tfd_pkg::*;

  logic [7:0]  byte_w;
  logic [3:0]  nib;
  logic [7:0]  nib_x11;
  logic [7:0]  nib_i3;
  logic [7:0]  nib_a1;
  logic [7:0]  bit_x;
  logic [15:0] w5551;

  // sub-byte selection: high nibble first, msb first for 1-bit
  assign byte_w  = word_i[7:0];
  assign nib     = idx_i[0] ? byte_w[3:0] : byte_w[7:4];
  assign nib_x11 = {nib, nib};
  assign nib_i3  = {nib[3:1], nib[3:1], 2'b00};
  assign nib_a1  = nib[0] ? 8'hFF : 8'h00;
  assign bit_x   = byte_w[~idx_i] ? 8'hFF : 8'h00;
  assign w5551   = (fmt_i == FMT_CI8) ? pal_word_i : word_i[15:0];

  // per-format channel mapping
  always_comb begin
    pix_o      = '0;
    pix_o.last = (idx_i == pix_last(fmt_i));
    unique case (fmt_i)
      FMT_RGBA16, FMT_CI8: begin
        pix_o.red   = WIDEN5[w5551[15:11]];
        pix_o.green = WIDEN5[w5551[10:6]];
        pix_o.blue  = WIDEN5[w5551[5:1]];
        pix_o.alpha = w5551[0] ? 8'hFF : 8'h00;
      end
      FMT_RGBA32: begin
        pix_o.red   = word_i[31:24];
        pix_o.green = word_i[23:16];
        pix_o.blue  = word_i[15:8];
        pix_o.alpha = word_i[7:0];
      end
      FMT_IA16: begin
        pix_o.red   = word_i[15:8];
        pix_o.green = word_i[15:8];
        pix_o.blue  = word_i[15:8];
        pix_o.alpha = word_i[7:0];
      end
      FMT_IA8: begin
        pix_o.red   = {byte_w[7:4], byte_w[7:4]};
        pix_o.green = {byte_w[7:4], byte_w[7:4]};
        pix_o.blue  = {byte_w[7:4], byte_w[7:4]};
        pix_o.alpha = {byte_w[3:0], byte_w[3:0]};
      end
      FMT_IA4: begin
        pix_o.red   = nib_i3;
        pix_o.green = nib_i3;
        pix_o.blue  = nib_i3;
        pix_o.alpha = nib_a1;
      end
      FMT_IA1: begin
        pix_o.red   = bit_x;
        pix_o.green = bit_x;
        pix_o.blue  = bit_x;
        pix_o.alpha = bit_x;
      end
      FMT_I8: begin
        pix_o.red   = byte_w;
        pix_o.green = byte_w;
        pix_o.blue  = byte_w;
        pix_o.alpha = 8'hFF;
      end
      FMT_I4: begin
        pix_o.red   = nib_x11;
        pix_o.green = nib_x11;
        pix_o.blue  = nib_x11;
        pix_o.alpha = 8'hFF;
      end
      default: begin
        pix_o = '0;
      end
    endcase
  end

endmodule

/* rtl/tfd_frame.sv */
// image size register and pixel counter that flags the last pixel
module tfd_frame (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tfd_pkg::DIM_W-1:0] width_i,
  input  logic [tfd_pkg::DIM_W-1:0] height_i,
  input  logic                      clear_i,
  input  logic                      step_i,
  output logic                      eoi_o
);
  import tfd_pkg::*;

  localparam int TOT_W  = COUNT_BITS + 1;
  localparam int PROD_W = 2 * DIM_W;
  localparam int CMP_W  = (PROD_W > TOT_W) ? PROD_W : TOT_W;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << COUNT_BITS;
  localparam logic [TOT_W-1:0] RESET_TOTAL = TOT_W'(1024);

  logic [PROD_W-1:0]     prod;
  logic [CMP_W-1:0]      prod_x;
  logic [TOT_W-1:0]      total_d, total_q;
  logic [COUNT_BITS-1:0] cnt_d, cnt_q;
  logic [TOT_W-1:0]      cnt_next;

  // saturated image size, zero read as one, registered off the multiplier
  assign prod   = PROD_W'(width_i) * PROD_W'(height_i);
  assign prod_x = CMP_W'(prod);
  always_comb begin
    priority if (prod_x > LIMIT) begin
      total_d = TOT_W'(LIMIT);
    end else if (prod_x == '0) begin
      total_d = TOT_W'(1);
    end else begin
      total_d = TOT_W'(prod_x);
    end
  end

  // end-of-image compare and counter update
  assign cnt_next = TOT_W'(cnt_q) + TOT_W'(1);
  assign eoi_o    = (cnt_next >= total_q);

  always_comb begin
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (step_i) begin
      cnt_d = eoi_o ? '0 : cnt_next[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= RESET_TOTAL;
      cnt_q   <= '0;
    end else begin
      total_q <= total_d;
      cnt_q   <= cnt_d;
    end
  end

  // counter stays inside the image
  a_cnt_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    TOT_W'(cnt_q) < total_q)
    else $error("pixel counter reached image size");

endmodule

/* rtl/texel_format_decoder.sv */
// top level: byte gathering, palette, pixel stage and output register
// a completing byte loads the pixel stage; its pixels then load the output register
// throughput: one byte per cycle for 1-pixel formats while the output is not stalled; a 4-bit
// or ia1 byte holds the pixel stage and the input until its last pixel is sent on
// palette writes and leading bytes of multi-byte pixels give no item
// reset sets rgba16, 32x32; clears gather state, pixel counter and valids; palette kept
module texel_format_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [7:0]                      data_byte_i,
  input  logic [7:0]                      palette_index_i,
  input  logic [15:0]                     palette_word_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [7:0]                      alpha_o,
  output logic                            last_of_byte_o,
  output logic                            end_of_image_o
);
  import tfd_pkg::*;

  localparam logic [8:0] PAL_LIM = 9'(PAL_ENTRIES);

  // configuration registers
  tex_fmt_e          fmt_q;
  logic [3:0]        fmt_raw_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic              cfg_clear;

  // gather state
  logic [1:0]        phase_d, phase_q;
  logic [HELD_W-1:0] held_d, held_q;
  logic [2:0]        need;
  logic              fmt_known;
  logic              hold;

  // handshake
  logic              in_acc;
  logic              texel_acc;
  logic              pal_we;
  logic              s_load;
  logic              out_adv;
  logic              out_load;
  logic              s_done;

  // pixel stage
  logic                 s_valid_q;
  tex_fmt_e             s_fmt_q;
  logic [WORD_W-1:0]    s_word_q;
  logic [PIX_IDX_W-1:0] s_idx_q;
  logic [15:0]          pal_rd_q;
  logic                 pal_oob_q;
  logic [15:0]          pal_word;
  pix_t                 pix;

  // palette memory
  logic [15:0]       pal_mem [PAL_ENTRIES];

  // output register
  logic              out_valid_q;
  pix_t              out_pix_q;
  logic              eoi, eoi_q;

  // configuration writes, any listed register restarts the image
  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FORMAT, REG_WIDTH, REG_HEIGHT: cfg_clear = 1'b1;
        default:                           cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_raw_q <= 4'(FMT_RGBA16);
      width_q   <= DIM_W'(32);
      height_q  <= DIM_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FORMAT: fmt_raw_q <= cfg_data_i[3:0];
        REG_WIDTH:  width_q   <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q  <= cfg_data_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign fmt_q     = tex_fmt_e'(fmt_raw_q);
  assign fmt_known = (fmt_raw_q <= 4'(FMT_CI8));

  // handshake and item routing
  assign out_adv    = !out_valid_q || out_ready_i;
  assign s_done     = s_valid_q && (s_idx_q == pix_last(s_fmt_q));
  assign in_ready_o = !s_valid_q || (out_adv && s_done);
  assign in_acc     = in_valid_i && in_ready_o;
  assign texel_acc  = in_acc && (item_op_e'(op_i) == OP_TEXEL) && fmt_known;
  assign pal_we     = in_acc && (item_op_e'(op_i) == OP_PALETTE)
                      && ({1'b0, palette_index_i} < PAL_LIM);
  assign out_load   = s_valid_q && out_adv;

  // bytes needed per pixel
  always_comb begin
    unique case (fmt_q)
      FMT_RGBA16, FMT_IA16: need = 3'd2;
      FMT_RGBA32:           need = 3'd4;
      default:              need = 3'd1;
    endcase
  end

  assign hold   = ({1'b0, phase_q} + 3'd1) < need;
  assign s_load = texel_acc && !hold;

  // gather leading bytes of multi-byte pixels
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (cfg_clear) begin
      phase_d = '0;
      held_d  = '0;
    end else if (texel_acc) begin
      if (hold) begin
        held_d  = {held_q[HELD_W-9:0], data_byte_i};
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = '0;
        held_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // palette write and registered lookup
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[palette_index_i[PAL_AW-1:0]] <= palette_word_i;
    end
    if (s_load) begin
      pal_rd_q  <= pal_mem[data_byte_i[PAL_AW-1:0]];
      pal_oob_q <= ({1'b0, data_byte_i} >= PAL_LIM);
    end
  end

  assign pal_word = pal_oob_q ? 16'h0000 : pal_rd_q;

  // pixel stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      s_idx_q   <= '0;
    end else if (s_load) begin
      s_valid_q <= 1'b1;
      s_idx_q   <= '0;
    end else if (out_load) begin
      if (s_done) begin
        s_valid_q <= 1'b0;
      end else begin
        s_idx_q <= s_idx_q + PIX_IDX_W'(1);
      end
    end
  end

  // pixel stage payload
  always_ff @(posedge clk_i) begin
    if (s_load) begin
      s_fmt_q  <= fmt_q;
      s_word_q <= {held_q, data_byte_i};
    end
  end

  tfd_pixel u_pixel (
    .fmt_i      (s_fmt_q),
    .word_i     (s_word_q),
    .pal_word_i (pal_word),
    .idx_i      (s_idx_q),
    .pix_o      (pix)
  );

  tfd_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .clear_i  (cfg_clear),
    .step_i   (out_load),
    .eoi_o    (eoi)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q <= pix;
      eoi_q     <= eoi;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = out_pix_q.red;
  assign green_o        = out_pix_q.green;
  assign blue_o         = out_pix_q.blue;
  assign alpha_o        = out_pix_q.alpha;
  assign last_of_byte_o = out_pix_q.last;
  assign end_of_image_o = eoi_q;

  // sub-pixel index never passes the byte's last pixel
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> (s_idx_q <= pix_last(s_fmt_q)))
    else $error("pixel index beyond last pixel of byte");

  // only rgba32 holds more than one leading byte
  a_phase_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fmt_q != FMT_RGBA32) |-> (phase_q <= 2'd1))
    else $error("gather phase too deep for format");

  // a completing byte starts the stage at its first pixel
  a_stage_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_load |=> (s_valid_q && (s_idx_q == '0)))
    else $error("stage not loaded after completing byte");

  // a pixel moves to the output only when the stage holds one
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s_valid_q))
    else $error("output item without stage pixel");

endmodule

/* tb/tb_texel_format_decoder.sv */
// self-checking testbench for the texel format decoder: directed and random byte streams
module tb_texel_format_decoder;
  import tfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 6;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // a format code outside the defined set
  localparam logic [3:0] FMT_UNKNOWN = 4'd15;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_HALF,
    RX_LONG_STALLS
  } rx_mode_e;

  // one expected pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_byte;
    logic       end_of_image;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op_in = OP_TEXEL;
  logic [7:0]            data_byte = '0;
  logic [7:0]            palette_index = '0;
  logic [15:0]           palette_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            red, green, blue, alpha;
  logic                  last_of_byte, end_of_image;

  // decoder model state
  logic [3:0]            fmt_q;
  logic [DIM_W-1:0]      width_q, height_q;
  logic [1:0]            phase_q;
  logic [HELD_W-1:0]     held_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [15:0]           palette_q [PAL_ENTRIES];
  bit                    pal_written [PAL_ENTRIES];
  logic [7:0]            written_idx [$];
  pixel_t                expected_pixels [$];

  int       errors = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       rx_cycle = 0;
  int       stall_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;

  texel_format_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op_in),
    .data_byte_i     (data_byte),
    .palette_index_i (palette_index),
    .palette_word_i  (palette_word),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .alpha_o         (alpha),
    .last_of_byte_o  (last_of_byte),
    .end_of_image_o  (end_of_image)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-length watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // 5-bit channel to 8 bits, truncating
  function automatic logic [7:0] widen5(logic [4:0] v);
    return 8'((int'(v) * 255) / 31);
  endfunction

  // queue a pixel and advance the image pixel count
  function automatic void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a, logic last);
    longint total;
    logic   eoi;
    total = longint'(width_q) * longint'(height_q);
    if (total > (longint'(1) << COUNT_BITS)) total = longint'(1) << COUNT_BITS;
    if (total == 0) total = 1;
    if (longint'(count_q) + 1 >= total) begin
      eoi = 1'b1;
      count_q = '0;
    end else begin
      eoi = 1'b0;
      count_q = count_q + 1'b1;
    end
    expected_pixels.push_back('{r, g, b, a, last, eoi});
  endfunction

  function automatic void push_5551(logic [15:0] w);
    push_pixel(widen5(w[15:11]), widen5(w[10:6]), widen5(w[5:1]),
               w[0] ? 8'hFF : 8'h00, 1'b1);
  endfunction

  // hold a leading byte; true once the byte completes a pixel
  function automatic bit gather_byte(logic [7:0] b, int need);
    if (int'(phase_q) + 1 < need) begin
      held_q = {held_q[15:0], b};
      phase_q = phase_q + 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected pixels for one accepted item
  function automatic void decode_item(logic op, logic [7:0] b, logic [7:0] pidx,
                                      logic [15:0] pword);
    logic [7:0] v;
    logic [3:0] nib;
    if (op == OP_PALETTE) begin
      palette_q[pidx] = pword;
      if (!pal_written[pidx]) begin
        pal_written[pidx] = 1'b1;
        written_idx.push_back(pidx);
      end
      return;
    end
    case (fmt_q)
      FMT_RGBA16: begin
        if (!gather_byte(b, 2)) return;
        push_5551({held_q[7:0], b});
      end
      FMT_RGBA32: begin
        if (!gather_byte(b, 4)) return;
        push_pixel(held_q[23:16], held_q[15:8], held_q[7:0], b, 1'b1);
      end
      FMT_IA16: begin
        if (!gather_byte(b, 2)) return;
        push_pixel(held_q[7:0], held_q[7:0], held_q[7:0], b, 1'b1);
      end
      FMT_IA8: begin
        v = b[7:4] * 8'h11;
        push_pixel(v, v, v, b[3:0] * 8'h11, 1'b1);
      end
      FMT_IA4: begin
        for (int i = 0; i < 2; i++) begin
          nib = (i == 0) ? b[7:4] : b[3:0];
          v = nib[3:1] * 8'h24;
          push_pixel(v, v, v, nib[0] ? 8'hFF : 8'h00, i == 1);
        end
      end
      FMT_IA1: begin
        for (int i = 0; i < 8; i++) begin
          v = b[7-i] ? 8'hFF : 8'h00;
          push_pixel(v, v, v, v, i == 7);
        end
      end
      FMT_I8: push_pixel(b, b, b, 8'hFF, 1'b1);
      FMT_I4: begin
        for (int i = 0; i < 2; i++) begin
          nib = (i == 0) ? b[7:4] : b[3:0];
          v = nib * 8'h11;
          push_pixel(v, v, v, 8'hFF, i == 1);
        end
      end
      FMT_CI8: push_5551(palette_q[b]);
      default: return;
    endcase
    phase_q = '0;
    held_q = '0;
  endfunction

  // register write effect; any known register restarts the image
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FORMAT: fmt_q = val[3:0];
      REG_WIDTH:  width_q = val;
      REG_HEIGHT: height_q = val;
      default:    return;
    endcase
    phase_q = '0;
    held_q = '0;
    count_q = '0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 11'd1;
      1:       return 11'd1024;
      2:       return 11'd0;
      3:       return 11'd2047;
      default: return 11'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (errors < 40)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // send one item, idling in random bursts, and predict once it is taken
  task automatic send_item(logic op, logic [7:0] b, logic [7:0] pidx, logic [15:0] pword);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    op_in         <= op;
    data_byte     <= b;
    palette_index <= pidx;
    palette_word  <= pword;
    do @(posedge clk); while (!in_ready);
    decode_item(op, b, pidx, pword);
  endtask

  task automatic send_texel(logic [7:0] b);
    send_item(OP_TEXEL, b, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_palette(logic [7:0] idx, logic [15:0] word);
    send_item(OP_PALETTE, 8'($urandom), idx, word);
  endtask

  // drop valid and let every expected pixel come out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_format(logic [3:0] f);
    wait_idle();
    write_reg(REG_FORMAT, CFG_DATA_W'(f));
  endtask

  // reset values, extremes, palette write between the two bytes of a pixel
  task automatic test_default_rgba16();
    send_texel(8'hFF);
    send_texel(8'hFF);
    send_texel(8'h00);
    send_palette(8'h5A, 16'h07C1);
    send_texel(8'h01);
  endtask

  // palette load at both ends of the index range, then lookups
  task automatic test_palette_ci8();
    send_palette(8'h00, 16'h0000);
    send_palette(8'hFF, 16'hFFFF);
    set_format(FMT_CI8);
    send_texel(8'h00);
    send_texel(8'hFF);
    send_texel(8'h5A);
  endtask

  // one pixel group in every format but rgba16 and ci8, plus an undefined format
  task automatic test_each_format();
    set_format(FMT_RGBA32);
    send_texel(8'h80);
    send_texel(8'h01);
    send_texel(8'hFF);
    send_texel(8'h00);
    set_format(FMT_IA16);
    send_texel(8'hFF);
    send_texel(8'h00);
    set_format(FMT_IA8);
    send_texel(8'hF0);
    set_format(FMT_IA4);
    send_texel(8'h9E);
    set_format(FMT_IA1);
    send_texel(8'hA5);
    set_format(FMT_I8);
    send_texel(8'hFF);
    set_format(FMT_I4);
    send_texel(8'h0F);
    set_format(FMT_UNKNOWN);
    send_texel(8'h55);
  endtask

  // image size corner cases and register writes mid-pixel
  task automatic test_image_bounds();
    // zero total: every pixel ends an image
    set_format(FMT_I8);
    write_reg(REG_WIDTH, 11'd0);
    send_texel(8'h12);
    // image end falls inside one byte
    set_format(FMT_IA1);
    write_reg(REG_WIDTH, 11'd3);
    write_reg(REG_HEIGHT, 11'd1);
    send_texel(8'hC3);
    // single-pixel image
    set_format(FMT_I4);
    write_reg(REG_WIDTH, 11'd1);
    send_texel(8'h3C);
    // saturated total
    wait_idle();
    write_reg(REG_WIDTH, 11'd2047);
    write_reg(REG_HEIGHT, 11'd2047);
    send_texel(8'h81);
    wait_idle();
    write_reg(REG_WIDTH, 11'd1024);
    write_reg(REG_HEIGHT, 11'd1024);
    // a register write drops a half-gathered pixel
    set_format(FMT_IA16);
    send_texel(8'hAB);
    wait_idle();
    write_reg(REG_HEIGHT, 11'd1);
    send_texel(8'h11);
    send_texel(8'h22);
    // a write to the spare index keeps the held byte
    send_texel(8'h77);
    wait_idle();
    write_reg(REG_SPARE, 11'h7FF);
    send_texel(8'h88);
  endtask

  // random settings, mostly whole pixels, some palette writes and cut-off pixels
  task automatic test_random_stream();
    int               sent;
    int               need;
    int               pixels;
    logic [3:0]       fmt;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0]       b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      fmt = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      val = {7'($urandom_range(0, 127)), fmt};
      if ($urandom_range(0, 3) != 0) val[10:4] = '0;
      write_reg(REG_FORMAT, val);
      if ($urandom_range(0, 3) != 0) write_reg(REG_WIDTH, pick_dim());
      if ($urandom_range(0, 3) != 0) write_reg(REG_HEIGHT, pick_dim());
      case (fmt)
        FMT_RGBA32:          need = 4;
        FMT_RGBA16, FMT_IA16: need = 2;
        default:             need = 1;
      endcase
      pixels = $urandom_range(2, 12);
      for (int p = 0; p < pixels; p++) begin
        for (int k = 0; k < need; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_palette(8'($urandom), 16'($urandom));
            sent++;
          end
          b = (fmt == FMT_CI8) ? written_idx[$urandom_range(0, written_idx.size() - 1)]
                               : 8'($urandom);
          send_texel(b);
          if (fmt <= FMT_CI8) sent++;
        end
      end
      // leave a pixel unfinished before the next register write
      if (need > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, need - 1)) begin
          send_texel(8'($urandom));
          sent++;
        end
      end
    end
  endtask

  // receiver ready pattern
  always @(negedge clk) begin
    logic nxt;
    rx_cycle++;
    if (rx_cycle % 80 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: nxt = 1'b1;
        RX_MOSTLY: nxt = ($urandom_range(0, 3) != 0);
        RX_HALF:   nxt = 1'($urandom_range(0, 1));
        default: begin
          nxt = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 15);
        end
      endcase
    end
    out_ready <= nxt;
  end

  // compare each pixel taken with the oldest expectation
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{red, green, blue, alpha, last_of_byte, end_of_image};
      if (expected_pixels.size() == 0) begin
        if (errors < 40) $display("%0t: unexpected pixel expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("alpha", want.alpha, got.alpha);
        check_field("last_of_byte", 8'(want.last_of_byte), 8'(got.last_of_byte));
        check_field("end_of_image", 8'(want.end_of_image), 8'(got.end_of_image));
      end
    end
  end

  // test sequence
  initial begin
    fmt_q    = FMT_RGBA16;
    width_q  = 11'd32;
    height_q = 11'd32;
    phase_q  = '0;
    held_q   = '0;
    count_q  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_rgba16();
    test_palette_ci8();
    test_each_format();
    test_image_bounds();
    test_random_stream();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tfd_pkg.sv
rtl/tfd_pixel.sv
rtl/tfd_frame.sv
rtl/texel_format_decoder.sv
tb/tb_texel_format_decoder.sv
